### hw/rtl/plp_pkg.sv
package plp_pkg;

  // table geometry
  localparam int TableDepth = 256;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);

  // field widths
  localparam int DataW    = 32;
  localparam int IndexW   = 8;
  localparam int CountW   = 9;
  localparam int InDataW  = 72;
  localparam int InUserW  = 1;
  localparam int OutDataW = 32;
  localparam int OutUserW = 2;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 32;

  // serial divider
  localparam int DivW    = 32;
  localparam int DvdW    = 2 * DivW;
  localparam int DivCntW = $clog2(DivW + 1);

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    REGION_INTERP = 2'd0,
    REGION_BELOW  = 2'd1,
    REGION_ABOVE  = 2'd2,
    REGION_CONST  = 2'd3
  } region_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POINT_COUNT    = 1'b0,
    CFG_CONSTANT_VALUE = 1'b1
  } cfg_reg_e;

endpackage

### hw/rtl/piecewise_linear_table_lookup.sv
// Piecewise-linear lookup over up to 256 breakpoints (signed Q16.16 time and
// value). A load item (tuser = 0) writes one breakpoint and returns nothing.
// A query item (tuser = 1) returns one result: the constant value when
// point_count is zero, the first or last value when the time lies outside the
// table, else the linear interpolation of the segment holding the time, found
// via the cached segment hint or a binary search. The block takes no new item
// while a query is in work. A query in constant mode goes straight to the
// result; any other query reads the first and, unless the time lies below it,
// the last breakpoint, then checks the hint segment, and after a missed hint
// runs a binary search of at most 8 steps, then one pass on the first segment
// when no segment holds the time. Each segment check reads its two breakpoints
// in turn over the single read port of the breakpoint memories, and the
// interpolation waits on the radix-2 divider.
// Breakpoints must be loaded before a query can reach them.
module piecewise_linear_table_lookup (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [plp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [plp_pkg::CfgDataW-1:0]  cfg_data_i,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // point_index[7:0], sample_time[39:8], sample_value[71:40]
  input  logic [plp_pkg::InDataW-1:0]   s_axis_tdata,
  // kind[0]
  input  logic [plp_pkg::InUserW-1:0]   s_axis_tuser,
  // results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // result_value[31:0]
  output logic [plp_pkg::OutDataW-1:0]  m_axis_tdata,
  // region[1:0]
  output logic [plp_pkg::OutUserW-1:0]  m_axis_tuser
);
  import plp_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE      = 14'h0001,
    S_FIRST     = 14'h0002,
    S_FIRST_CHK = 14'h0004,
    S_LAST      = 14'h0008,
    S_LAST_CHK  = 14'h0010,
    S_SRCH      = 14'h0020,
    S_PA        = 14'h0040,
    S_PB        = 14'h0080,
    S_PC        = 14'h0100,
    S_PREP      = 14'h0200,
    S_MUL       = 14'h0400,
    S_DSTART    = 14'h0800,
    S_DWAIT     = 14'h1000,
    S_OUT       = 14'h2000
  } state_e;

  typedef enum logic [1:0] {
    PM_HINT   = 2'd0,
    PM_SEARCH = 2'd1,
    PM_FINAL  = 2'd2
  } pair_mode_e;

  // input unpack
  logic [IndexW-1:0]       in_index;
  logic signed [DataW-1:0] in_time;
  logic [DataW-1:0]        in_value;
  kind_e                   in_kind;
  logic                    in_acc;

  assign in_index = s_axis_tdata[IndexW-1:0];
  assign in_time  = $signed(s_axis_tdata[IndexW+DataW-1:IndexW]);
  assign in_value = s_axis_tdata[IndexW+2*DataW-1:IndexW+DataW];
  assign in_kind  = kind_e'(s_axis_tuser[0]);
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // registers
  state_e                   state_q, state_d;
  pair_mode_e               mode_q, mode_d;
  logic [AddrW-1:0]         hint_q, hint_d;
  logic                     out_valid_q, out_valid_d;
  logic [CountW-1:0]        point_count_q;
  logic [DataW-1:0]         const_q;

  logic signed [DataW-1:0]  tq_q, tq_d;
  logic [CntW-1:0]          n_q, n_d;
  logic [AddrW-1:0]         seg_q, seg_d;
  logic signed [CntW:0]     lo_q, lo_d, hi_q, hi_d;
  logic signed [DataW-1:0]  t0_q, t0_d, t1_q, t1_d, v0_q, v0_d, v1_q, v1_d;
  logic [DivW-1:0]          span_q, span_d, dtc_q, dtc_d, mag_q, mag_d;
  logic                     neg_q, neg_d;
  logic [DvdW-1:0]          prod_q, prod_d;
  logic [DataW-1:0]         res_q, res_d;
  region_e                  region_q, region_d;
  logic [DataW-1:0]         out_data_q, out_data_d;
  region_e                  out_region_q, out_region_d;

  // memory and divider
  logic                     mem_we;
  logic [AddrW-1:0]         rd_addr;
  logic [DataW-1:0]         time_rd, value_rd;
  logic                     div_start, div_done;
  logic [DivW-1:0]          div_quo;

  // combinational helpers
  logic [CntW-1:0]          n_eff;
  logic signed [CntW:0]     mid_w, seg_ext;
  logic signed [DataW:0]    span_w, dt_w, dv_w;
  logic signed [DataW+1:0]  sum_w;
  logic                     hit;
  logic                     out_load;

  assign n_eff = (32'(point_count_q) > TableDepth) ? CntW'(TableDepth) : CntW'(point_count_q);

  assign mem_we = in_acc && (in_kind == KIND_LOAD) && (32'(in_index) < TableDepth);

  plp_ram #(.Width(DataW), .Depth(TableDepth)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AddrW'(in_index)),
    .wdata_i (in_time),
    .raddr_i (rd_addr),
    .rdata_o (time_rd)
  );

  plp_ram #(.Width(DataW), .Depth(TableDepth)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AddrW'(in_index)),
    .wdata_i (in_value),
    .raddr_i (rd_addr),
    .rdata_o (value_rd)
  );

  plp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (span_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign mid_w   = lo_q + ((hi_q - lo_q) >>> 1);
  assign seg_ext = signed'((CntW+1)'(seg_q));
  assign hit     = (tq_q >= t0_q) && (tq_q < $signed(time_rd));
  assign span_w  = {t1_q[DataW-1], t1_q} - {t0_q[DataW-1], t0_q};
  assign dt_w    = {tq_q[DataW-1], tq_q} - {t0_q[DataW-1], t0_q};
  assign dv_w    = {v1_q[DataW-1], v1_q} - {v0_q[DataW-1], v0_q};
  assign sum_w   = neg_q ? ({{2{v0_q[DataW-1]}}, v0_q} - {2'b00, div_quo})
                         : ({{2{v0_q[DataW-1]}}, v0_q} + {2'b00, div_quo});

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    hint_d    = hint_q;
    tq_d      = tq_q;
    n_d       = n_q;
    seg_d     = seg_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    t0_d      = t0_q;
    t1_d      = t1_q;
    v0_d      = v0_q;
    v1_d      = v1_q;
    span_d    = span_q;
    dtc_d     = dtc_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    prod_d    = prod_q;
    res_d     = res_q;
    region_d  = region_q;
    rd_addr   = '0;
    div_start = 1'b0;
    out_load  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc && in_kind == KIND_QUERY) begin
          tq_d = in_time;
          n_d  = n_eff;
          if (n_eff == '0) begin
            res_d    = const_q;
            region_d = REGION_CONST;
            state_d  = S_OUT;
          end else begin
            state_d = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        rd_addr = '0;
        state_d = S_FIRST_CHK;
      end
      S_FIRST_CHK: begin
        if (tq_q < $signed(time_rd)) begin
          res_d    = value_rd;
          region_d = REGION_BELOW;
          state_d  = S_OUT;
        end else begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        rd_addr = AddrW'(n_q - 1'b1);
        state_d = S_LAST_CHK;
      end
      S_LAST_CHK: begin
        if (tq_q >= $signed(time_rd)) begin
          res_d    = value_rd;
          region_d = REGION_ABOVE;
          state_d  = S_OUT;
        end else if ((CntW+1)'(hint_q) + (CntW+1)'(1) < (CntW+1)'(n_q)) begin
          seg_d   = hint_q;
          mode_d  = PM_HINT;
          state_d = S_PA;
        end else begin
          lo_d    = '0;
          hi_d    = signed'((CntW+1)'(n_q)) - (CntW+1)'(2);
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_q <= hi_q) begin
          seg_d  = AddrW'(mid_w);
          mode_d = PM_SEARCH;
        end else begin
          // no segment found: fall back to the first one
          seg_d  = '0;
          mode_d = PM_FINAL;
        end
        state_d = S_PA;
      end
      S_PA: begin
        rd_addr = seg_q;
        state_d = S_PB;
      end
      S_PB: begin
        rd_addr = seg_q + AddrW'(1);
        t0_d    = $signed(time_rd);
        v0_d    = $signed(value_rd);
        state_d = S_PC;
      end
      S_PC: begin
        t1_d = $signed(time_rd);
        v1_d = $signed(value_rd);
        if (mode_q == PM_FINAL || hit) begin
          hint_d  = seg_q;
          state_d = S_PREP;
        end else if (mode_q == PM_HINT) begin
          lo_d    = '0;
          hi_d    = signed'((CntW+1)'(n_q)) - (CntW+1)'(2);
          state_d = S_SRCH;
        end else begin
          if (tq_q < t0_q) begin
            hi_d = seg_ext - (CntW+1)'(1);
          end else begin
            lo_d = seg_ext + (CntW+1)'(1);
          end
          state_d = S_SRCH;
        end
      end
      S_PREP: begin
        region_d = REGION_INTERP;
        if (span_w <= 0) begin
          res_d   = v0_q;
          state_d = S_OUT;
        end else begin
          span_d = span_w[DivW-1:0];
          if (dt_w < 0) begin
            dtc_d = '0;
          end else if (dt_w > span_w) begin
            dtc_d = span_w[DivW-1:0];
          end else begin
            dtc_d = dt_w[DivW-1:0];
          end
          neg_d   = (dv_w < 0);
          mag_d   = (dv_w < 0) ? DivW'(-dv_w) : dv_w[DivW-1:0];
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = DvdW'(mag_q) * DvdW'(dtc_q);
        state_d = S_DSTART;
      end
      S_DSTART: begin
        div_start = 1'b1;
        state_d   = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          if (sum_w > 34'sd2147483647) begin
            res_d = {1'b0, {(DataW-1){1'b1}}};
          end else if (sum_w < -34'sd2147483648) begin
            res_d = {1'b1, {(DataW-1){1'b0}}};
          end else begin
            res_d = sum_w[DataW-1:0];
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_data_d   = out_data_q;
    out_region_d = out_region_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_data_d   = res_q;
      out_region_d = region_q;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      mode_q        <= PM_HINT;
      hint_q        <= '0;
      out_valid_q   <= 1'b0;
      point_count_q <= '0;
      const_q       <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      hint_q      <= hint_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_POINT_COUNT:    point_count_q <= cfg_data_i[CountW-1:0];
          CFG_CONSTANT_VALUE: const_q       <= cfg_data_i[DataW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tq_q         <= tq_d;
    n_q          <= n_d;
    seg_q        <= seg_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    t0_q         <= t0_d;
    t1_q         <= t1_d;
    v0_q         <= v0_d;
    v1_q         <= v1_d;
    span_q       <= span_d;
    dtc_q        <= dtc_d;
    mag_q        <= mag_d;
    neg_q        <= neg_d;
    prod_q       <= prod_d;
    res_q        <= res_d;
    region_q     <= region_d;
    out_data_q   <= out_data_d;
    out_region_q <= out_region_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_region_q;

  // divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DWAIT))
    else $error("divider done outside of wait state");

  // the hint always tracks the segment being interpolated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PREP) |-> (hint_q == seg_q))
    else $error("segment hint not updated before interpolation");

  // a load item never starts the query sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_kind == KIND_LOAD) |=> (state_q == S_IDLE))
    else $error("load item left idle state");

  // constant mode never reaches the table end read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LAST) |-> (n_q != '0))
    else $error("table read with zero points");

  // a finished result lands in a free output register on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !out_valid_q) |=> (m_axis_tvalid && m_axis_tdata == $past(res_q)))
    else $error("result not presented after completion");

endmodule

### hw/rtl/plp_ram.sv
module plp_ram #(
  parameter int Width = 32,
  parameter int Depth = 256,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/plp_div.sv
module plp_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [plp_pkg::DvdW-1:0]  dividend_i,
  input  logic [plp_pkg::DivW-1:0]  divisor_i,
  output logic                      done_o,
  output logic [plp_pkg::DivW-1:0]  quotient_o
);
  import plp_pkg::*;

  logic [DivW-1:0]    rem_q, rem_d;
  logic [DivW-1:0]    quo_q, quo_d;
  logic [DivW-1:0]    dsr_q, dsr_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [DivW+1:0]    trial;

  // one restoring step per cycle; quotient bits shift in behind the dividend bits
  assign trial = {1'b0, rem_q, quo_q[DivW-1]} - {2'b00, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = dividend_i[DvdW-1:DivW];
      quo_d = dividend_i[DivW-1:0];
      dsr_d = divisor_i;
      cnt_d = DivCntW'(DivW);
    end else if (cnt_q != '0) begin
      if (!trial[DivW+1]) begin
        rem_d = trial[DivW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivW-2:0], quo_q[DivW-1]};
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == DivCntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
